/* src/ltsc_pkg.sv */
// Shared types and character constants for the link tag stylesheet classifier.
`timescale 1ns / 1ps

package ltsc_pkg;

    typedef enum logic [7:0] {
        PH_DONE      = 8'b0000_0001,
        PH_SKIP      = 8'b0000_0010,
        PH_BETWEEN   = 8'b0000_0100,
        PH_NAME      = 8'b0000_1000,
        PH_AFTERNAME = 8'b0001_0000,
        PH_AFTEREQ   = 8'b0010_0000,
        PH_UVAL      = 8'b0100_0000,
        PH_QVAL      = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [1:0] name_matched;
        logic       name_differs;
        logic       quote_single;
        logic [3:0] token_matched;
        logic       token_differs;
    } parse_state_t;

    typedef struct packed {
        logic [7:0] tag_byte;
        logic       first;
        logic       last;
    } tag_item_t;

    typedef struct packed {
        logic is_stylesheet;
        logic rel_seen;
    } verdict_t;

    localparam parse_state_t PARSE_RESET = '{PH_DONE, 2'd0, 1'b0, 1'b0, 4'd0, 1'b0};

    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_FF    = 8'h0C;

    localparam logic [1:0] REL_LEN   = 2'd3;
    localparam logic [3:0] SHEET_LEN = 4'd10;

endpackage

/* src/ltsc_stream_if.sv */
// Valid/ready channel carrying one item of a given payload type.
`timescale 1ns / 1ps

interface ltsc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/ltsc_step.sv */
// Next-state and verdict logic for one tag byte.
`timescale 1ns / 1ps

module ltsc_step (
    input  ltsc_pkg::parse_state_t cur,
    input  ltsc_pkg::tag_item_t    item,
    output ltsc_pkg::parse_state_t nxt,
    output logic                   hit,
    output ltsc_pkg::verdict_t     verdict
);

    typedef struct packed {
        ltsc_pkg::parse_state_t st;
        logic                   hit;
        ltsc_pkg::verdict_t     v;
    } step_t;

    function automatic logic is_space(logic [7:0] c);
        return c == ltsc_pkg::CH_SP || c == ltsc_pkg::CH_TAB || c == ltsc_pkg::CH_LF
            || c == ltsc_pkg::CH_CR || c == ltsc_pkg::CH_FF;
    endfunction

    function automatic logic [7:0] to_lower(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] rel_char(logic [1:0] i);
        logic [7:0] r;
        unique case (i)
            2'd0:    r = 8'h72; // r
            2'd1:    r = 8'h65; // e
            default: r = 8'h6C; // l
        endcase
        return r;
    endfunction

    function automatic logic [7:0] sheet_char(logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0:    r = 8'h73; // s
            4'd1:    r = 8'h74; // t
            4'd2:    r = 8'h79; // y
            4'd3:    r = 8'h6C; // l
            4'd4:    r = 8'h65; // e
            4'd5:    r = 8'h73; // s
            4'd6:    r = 8'h68; // h
            4'd7:    r = 8'h65; // e
            4'd8:    r = 8'h65; // e
            default: r = 8'h74; // t
        endcase
        return r;
    endfunction

    function automatic logic is_rel(ltsc_pkg::parse_state_t s);
        return s.name_matched == ltsc_pkg::REL_LEN && !s.name_differs;
    endfunction

    function automatic logic token_hit(ltsc_pkg::parse_state_t s);
        return s.token_matched == ltsc_pkg::SHEET_LEN && !s.token_differs;
    endfunction

    function automatic ltsc_pkg::parse_state_t token_clear(ltsc_pkg::parse_state_t s);
        ltsc_pkg::parse_state_t r;
        r = s;
        r.token_matched = 4'd0;
        r.token_differs = 1'b0;
        return r;
    endfunction

    function automatic ltsc_pkg::parse_state_t token_char(ltsc_pkg::parse_state_t s,
                                                          logic [7:0] c);
        ltsc_pkg::parse_state_t r;
        r = s;
        if (!s.token_differs)
        begin
            if (s.token_matched < ltsc_pkg::SHEET_LEN
                && to_lower(c) == sheet_char(s.token_matched))
                r.token_matched = s.token_matched + 4'd1;
            else
                r.token_differs = 1'b1;
        end
        return r;
    endfunction

    function automatic step_t none(ltsc_pkg::parse_state_t s);
        step_t r;
        r.st  = s;
        r.hit = 1'b0;
        r.v   = '0;
        return r;
    endfunction

    function automatic step_t finish(ltsc_pkg::parse_state_t s, logic style, logic rel);
        step_t r;
        r.st       = s;
        r.st.phase = ltsc_pkg::PH_DONE;
        r.hit      = 1'b1;
        r.v        = '{style, rel};
        return r;
    endfunction

    function automatic step_t name_char(ltsc_pkg::parse_state_t s, logic [7:0] c);
        ltsc_pkg::parse_state_t r;
        r = s;
        if (is_space(c))
        begin
            r.phase = ltsc_pkg::PH_AFTERNAME;
            return none(r);
        end
        if (c == ltsc_pkg::CH_EQ)
        begin
            r.phase = ltsc_pkg::PH_AFTEREQ;
            return none(r);
        end
        if (c == ltsc_pkg::CH_GT || c == ltsc_pkg::CH_SLASH)
        begin
            if (is_rel(s))
                return finish(s, 1'b0, 1'b1);
            if (c == ltsc_pkg::CH_GT)
                return finish(s, 1'b0, 1'b0);
            r.phase = ltsc_pkg::PH_BETWEEN;
            return none(r);
        end
        if (!s.name_differs)
        begin
            if (s.name_matched < ltsc_pkg::REL_LEN
                && to_lower(c) == rel_char(s.name_matched))
                r.name_matched = s.name_matched + 2'd1;
            else
                r.name_differs = 1'b1;
        end
        return none(r);
    endfunction

    function automatic step_t between_char(ltsc_pkg::parse_state_t s, logic [7:0] c);
        ltsc_pkg::parse_state_t r;
        r = s;
        if (is_space(c) || c == ltsc_pkg::CH_SLASH)
        begin
            r.phase = ltsc_pkg::PH_BETWEEN;
            return none(r);
        end
        if (c == ltsc_pkg::CH_GT)
            return finish(s, 1'b0, 1'b0);
        r.name_matched = 2'd0;
        r.name_differs = 1'b0;
        r = token_clear(r);
        r.phase = ltsc_pkg::PH_NAME;
        return name_char(r, c);
    endfunction

    function automatic step_t uval_char(ltsc_pkg::parse_state_t s, logic [7:0] c);
        ltsc_pkg::parse_state_t r;
        r = s;
        if (is_space(c) || c == ltsc_pkg::CH_GT)
        begin
            if (is_rel(s))
                return finish(s, token_hit(s), 1'b1);
            if (c == ltsc_pkg::CH_GT)
                return finish(s, 1'b0, 1'b0);
            r.phase = ltsc_pkg::PH_BETWEEN;
            return none(r);
        end
        return none(token_char(s, c));
    endfunction

    function automatic step_t feed(ltsc_pkg::parse_state_t s, logic [7:0] c);
        ltsc_pkg::parse_state_t r;
        logic                   close_q;
        r = s;
        close_q = s.quote_single ? (c == ltsc_pkg::CH_SQ) : (c == ltsc_pkg::CH_DQ);
        unique case (s.phase)
            ltsc_pkg::PH_SKIP:
            begin
                if (c == ltsc_pkg::CH_GT)
                    return finish(s, 1'b0, 1'b0);
                if (is_space(c))
                    r.phase = ltsc_pkg::PH_BETWEEN;
                return none(r);
            end
            ltsc_pkg::PH_BETWEEN:
                return between_char(s, c);
            ltsc_pkg::PH_NAME:
                return name_char(s, c);
            ltsc_pkg::PH_AFTERNAME:
            begin
                if (is_space(c))
                    return none(s);
                if (c == ltsc_pkg::CH_EQ)
                begin
                    r.phase = ltsc_pkg::PH_AFTEREQ;
                    return none(r);
                end
                if (is_rel(s))
                    return finish(s, 1'b0, 1'b1);
                return between_char(s, c);
            end
            ltsc_pkg::PH_AFTEREQ:
            begin
                if (is_space(c))
                    return none(s);
                r = token_clear(s);
                if (c == ltsc_pkg::CH_DQ || c == ltsc_pkg::CH_SQ)
                begin
                    r.quote_single = (c == ltsc_pkg::CH_SQ);
                    r.phase        = ltsc_pkg::PH_QVAL;
                    return none(r);
                end
                r.phase = ltsc_pkg::PH_UVAL;
                return uval_char(r, c);
            end
            ltsc_pkg::PH_UVAL:
                return uval_char(s, c);
            ltsc_pkg::PH_QVAL:
            begin
                if (close_q)
                begin
                    if (is_rel(s))
                        return finish(s, token_hit(s), 1'b1);
                    r.phase = ltsc_pkg::PH_BETWEEN;
                    return none(r);
                end
                // early positive verdict on a matching token followed by whitespace
                if (is_space(c))
                begin
                    if (is_rel(s) && token_hit(s))
                        return finish(s, 1'b1, 1'b1);
                    return none(token_clear(s));
                end
                return none(token_char(s, c));
            end
            default:
                return none(s);
        endcase
    endfunction

    ltsc_pkg::parse_state_t start;
    step_t                  res;

    always_comb
    begin
        start = cur;
        if (item.first)
        begin
            start       = ltsc_pkg::PARSE_RESET;
            start.phase = ltsc_pkg::PH_SKIP;
        end
        if (start.phase == ltsc_pkg::PH_DONE)
            res = none(start);
        else
        begin
            res = feed(start, item.tag_byte);
            if (!res.hit && item.last)
            begin
                if ((res.st.phase == ltsc_pkg::PH_NAME || res.st.phase == ltsc_pkg::PH_AFTERNAME
                     || res.st.phase == ltsc_pkg::PH_AFTEREQ || res.st.phase == ltsc_pkg::PH_UVAL
                     || res.st.phase == ltsc_pkg::PH_QVAL) && is_rel(res.st))
                    res = finish(res.st, token_hit(res.st), 1'b1);
                else
                    res = finish(res.st, 1'b0, 1'b0);
            end
        end
    end

    assign nxt     = res.st;
    assign hit     = res.hit;
    assign verdict = res.v;

endmodule

/* src/link_tag_stylesheet_classifier_unit.sv */
// Accepted items wait in the byte register; a verdict they yield moves into the verdict register.
// Throughput: one tag byte per cycle; the byte register and the verdict register both
// advance whenever the verdict register is empty or being taken.
// Reset (rst_n low, asynchronous): both stages empty, parser waits for a first byte.
// Bytes arriving before any first byte produce nothing.
`timescale 1ns / 1ps

module link_tag_stylesheet_classifier_unit (
    input  logic                clk,
    input  logic                rst_n,
    ltsc_stream_if.sink         tag_in,
    ltsc_stream_if.source       verdict_out
);

    // Byte stage: holds one accepted item until the parser consumes it.
    logic                   byte_valid_reg;
    logic                   byte_valid_next;
    ltsc_pkg::tag_item_t    byte_item_reg;

    // Parser state, updated once per consumed byte.
    ltsc_pkg::parse_state_t state_reg;
    ltsc_pkg::parse_state_t state_next;

    // Verdict stage: output register toward the sink.
    logic                   out_valid_reg;
    logic                   out_valid_next;
    ltsc_pkg::verdict_t     out_data_reg;

    logic                   step_hit;
    ltsc_pkg::verdict_t     step_verdict;
    logic                   out_free;
    logic                   byte_adv;
    logic                   in_take;

    ltsc_step u_step (
        .cur     (state_reg),
        .item    (byte_item_reg),
        .nxt     (state_next),
        .hit     (step_hit),
        .verdict (step_verdict)
    );

    // The byte stage moves on when the verdict register can take a new value.
    assign out_free     = !out_valid_reg || verdict_out.ready;
    assign byte_adv     = byte_valid_reg && out_free;
    assign tag_in.ready = !byte_valid_reg || byte_adv;
    assign in_take      = tag_in.valid && tag_in.ready;

    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        if (in_take)
            byte_valid_next = 1'b1;
        else if (byte_adv)
            byte_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (byte_adv)
            out_valid_next = step_hit;
        else if (verdict_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= ltsc_pkg::PARSE_RESET;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
            out_valid_reg  <= out_valid_next;
            if (byte_adv)
                state_reg <= state_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
            byte_item_reg <= tag_in.data;
        if (byte_adv && step_hit)
            out_data_reg <= step_verdict;
    end

    assign verdict_out.valid = out_valid_reg;
    assign verdict_out.data  = out_data_reg;

endmodule

/* tb/ltsc_verdict_checker.sv */
// Checker for the stylesheet classifier: predicts each tag verdict and compares the verdict stream.
`timescale 1ns / 1ps

module ltsc_verdict_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tag_valid,
    input  logic                tag_ready,
    input  ltsc_pkg::tag_item_t tag_data,
    input  logic                verdict_valid,
    input  logic                verdict_ready,
    input  ltsc_pkg::verdict_t  verdict_data,
    output int                  mismatches,
    output int                  verdicts_pending,
    output int                  verdicts_checked,
    output int                  stylesheet_count
);

    localparam logic [23:0] REL_TEXT   = "rel";
    localparam logic [79:0] SHEET_TEXT = "stylesheet";

    ltsc_pkg::parse_state_t pst = ltsc_pkg::PARSE_RESET;
    bit                     decided;
    ltsc_pkg::verdict_t     decision;
    ltsc_pkg::verdict_t     expected_verdicts[$];

    int n_mismatch = 0;
    int n_pending  = 0;
    int n_checked  = 0;
    int n_sheet    = 0;

    assign mismatches       = n_mismatch;
    assign verdicts_pending = n_pending;
    assign verdicts_checked = n_checked;
    assign stylesheet_count = n_sheet;

    function automatic bit is_ws(logic [7:0] c);
        return c == ltsc_pkg::CH_SP || c == ltsc_pkg::CH_TAB || c == ltsc_pkg::CH_LF
            || c == ltsc_pkg::CH_CR || c == ltsc_pkg::CH_FF;
    endfunction

    function automatic logic [7:0] fold_case(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic bit rel_hit();
        return pst.name_matched == ltsc_pkg::REL_LEN && !pst.name_differs;
    endfunction

    function automatic bit sheet_hit();
        return pst.token_matched == ltsc_pkg::SHEET_LEN && !pst.token_differs;
    endfunction

    function automatic void conclude(bit style, bit rel);
        pst.phase = ltsc_pkg::PH_DONE;
        decided   = 1'b1;
        decision  = '{is_stylesheet: style, rel_seen: rel};
    endfunction

    function automatic void token_clear();
        pst.token_matched = '0;
        pst.token_differs = 1'b0;
    endfunction

    function automatic void token_char(logic [7:0] c);
        int idx;
        idx = pst.token_matched;
        if (!pst.token_differs)
        begin
            if (pst.token_matched < ltsc_pkg::SHEET_LEN
                && fold_case(c) == SHEET_TEXT[79 - 8 * idx -: 8])
                pst.token_matched++;
            else
                pst.token_differs = 1'b1;
        end
    endfunction

    function automatic void name_char(logic [7:0] c);
        int idx;
        idx = pst.name_matched;
        if (is_ws(c))
            pst.phase = ltsc_pkg::PH_AFTERNAME;
        else if (c == ltsc_pkg::CH_EQ)
            pst.phase = ltsc_pkg::PH_AFTEREQ;
        else if (c == ltsc_pkg::CH_GT || c == ltsc_pkg::CH_SLASH)
        begin
            if (rel_hit())
                conclude(1'b0, 1'b1);
            else if (c == ltsc_pkg::CH_GT)
                conclude(1'b0, 1'b0);
            else
                pst.phase = ltsc_pkg::PH_BETWEEN;
        end
        else if (!pst.name_differs)
        begin
            if (pst.name_matched < ltsc_pkg::REL_LEN
                && fold_case(c) == REL_TEXT[23 - 8 * idx -: 8])
                pst.name_matched++;
            else
                pst.name_differs = 1'b1;
        end
    endfunction

    function automatic void between_char(logic [7:0] c);
        if (is_ws(c) || c == ltsc_pkg::CH_SLASH)
            pst.phase = ltsc_pkg::PH_BETWEEN;
        else if (c == ltsc_pkg::CH_GT)
            conclude(1'b0, 1'b0);
        else
        begin
            pst.name_matched = '0;
            pst.name_differs = 1'b0;
            token_clear();
            pst.phase = ltsc_pkg::PH_NAME;
            name_char(c);
        end
    endfunction

    function automatic void uval_char(logic [7:0] c);
        if (is_ws(c) || c == ltsc_pkg::CH_GT)
        begin
            if (rel_hit())
                conclude(sheet_hit(), 1'b1);
            else if (c == ltsc_pkg::CH_GT)
                conclude(1'b0, 1'b0);
            else
                pst.phase = ltsc_pkg::PH_BETWEEN;
        end
        else
            token_char(c);
    endfunction

    // One tag byte through the parser; sets decided/decision when a verdict falls out.
    function automatic void classify_byte(ltsc_pkg::tag_item_t it);
        logic [7:0] c;
        c = it.tag_byte;
        decided = 1'b0;
        if (it.first)
        begin
            pst = ltsc_pkg::PARSE_RESET;
            pst.phase = ltsc_pkg::PH_SKIP;
        end
        if (pst.phase != ltsc_pkg::PH_DONE)
        begin
            unique case (pst.phase)
                ltsc_pkg::PH_SKIP:
                begin
                    if (c == ltsc_pkg::CH_GT)
                        conclude(1'b0, 1'b0);
                    else if (is_ws(c))
                        pst.phase = ltsc_pkg::PH_BETWEEN;
                end
                ltsc_pkg::PH_BETWEEN: between_char(c);
                ltsc_pkg::PH_NAME:    name_char(c);
                ltsc_pkg::PH_AFTERNAME:
                begin
                    if (!is_ws(c))
                    begin
                        if (c == ltsc_pkg::CH_EQ)
                            pst.phase = ltsc_pkg::PH_AFTEREQ;
                        else if (rel_hit())
                            conclude(1'b0, 1'b1);
                        else
                            between_char(c);
                    end
                end
                ltsc_pkg::PH_AFTEREQ:
                begin
                    if (!is_ws(c))
                    begin
                        token_clear();
                        if (c == ltsc_pkg::CH_DQ || c == ltsc_pkg::CH_SQ)
                        begin
                            pst.quote_single = (c == ltsc_pkg::CH_SQ);
                            pst.phase = ltsc_pkg::PH_QVAL;
                        end
                        else
                        begin
                            pst.phase = ltsc_pkg::PH_UVAL;
                            uval_char(c);
                        end
                    end
                end
                ltsc_pkg::PH_UVAL: uval_char(c);
                ltsc_pkg::PH_QVAL:
                begin
                    if (c == (pst.quote_single ? ltsc_pkg::CH_SQ : ltsc_pkg::CH_DQ))
                    begin
                        if (rel_hit())
                            conclude(sheet_hit(), 1'b1);
                        else
                            pst.phase = ltsc_pkg::PH_BETWEEN;
                    end
                    else if (is_ws(c))
                    begin
                        // quoted value may decide early on a matching token
                        if (rel_hit() && sheet_hit())
                            conclude(1'b1, 1'b1);
                        else
                            token_clear();
                    end
                    else
                        token_char(c);
                end
                default: ;
            endcase
            if (!decided && it.last)
            begin
                if (pst.phase != ltsc_pkg::PH_SKIP && pst.phase != ltsc_pkg::PH_BETWEEN
                    && rel_hit())
                    conclude(sheet_hit(), 1'b1);
                else
                    conclude(1'b0, 1'b0);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        ltsc_pkg::verdict_t want;
        if (rst_n)
        begin
            if (verdict_valid && verdict_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected verdict: expected none, %s=%0b rel_seen=%0b",
                             $time, "got is_stylesheet", verdict_data.is_stylesheet,
                             verdict_data.rel_seen);
                    n_mismatch++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (verdict_data.is_stylesheet !== want.is_stylesheet)
                    begin
                        $display("%0t: is_stylesheet mismatch: expected %0b, got %0b",
                                 $time, want.is_stylesheet, verdict_data.is_stylesheet);
                        n_mismatch++;
                    end
                    if (verdict_data.rel_seen !== want.rel_seen)
                    begin
                        $display("%0t: rel_seen mismatch: expected %0b, got %0b",
                                 $time, want.rel_seen, verdict_data.rel_seen);
                        n_mismatch++;
                    end
                    n_checked++;
                end
            end
            if (tag_valid && tag_ready)
            begin
                classify_byte(tag_data);
                if (decided)
                begin
                    expected_verdicts = {expected_verdicts, decision};
                    if (decision.is_stylesheet)
                        n_sheet++;
                end
            end
            n_pending = expected_verdicts.size();
        end
    end

endmodule

/* tb/tb_link_tag_stylesheet_classifier_unit.sv */
// Testbench top for the link tag stylesheet classifier: stimulus, idling phases and verdict.
`timescale 1ns / 1ps

module tb_link_tag_stylesheet_classifier_unit;

    logic       clk;
    logic       rst_n;

    // idling percentages, changed between tags by the stimulus process
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;

    int         bytes_sent = 0;
    int         tags_sent  = 0;
    int         byte_goal;
    int         rand_tags;
    int         idle_phase;
    bit         mark_last;

    int         mismatches;
    int         verdicts_pending;
    int         verdicts_checked;
    int         stylesheet_count;

    // bytes of the tag being composed
    logic [7:0] tag_text[$];

    ltsc_stream_if #(.T(ltsc_pkg::tag_item_t)) tag_if ();
    ltsc_stream_if #(.T(ltsc_pkg::verdict_t))  verdict_if ();

    link_tag_stylesheet_classifier_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .tag_in      (tag_if),
        .verdict_out (verdict_if)
    );

    ltsc_verdict_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .tag_valid        (tag_if.valid),
        .tag_ready        (tag_if.ready),
        .tag_data         (tag_if.data),
        .verdict_valid    (verdict_if.valid),
        .verdict_ready    (verdict_if.ready),
        .verdict_data     (verdict_if.data),
        .mismatches       (mismatches),
        .verdicts_pending (verdicts_pending),
        .verdicts_checked (verdicts_checked),
        .stylesheet_count (stylesheet_count)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Verdict side: ready is redrawn at every falling edge, so stalls land on any cycle
    // of the parser's work, including the one right after a verdict is produced.
    always @(negedge clk)
    begin
        verdict_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard stop in case the block hangs; far beyond the slowest legal run.
    initial
    begin
        #3_000_000;
        $display("timeout: run did not drain");
        $display("** link_tag_stylesheet_classifier_unit: FAILED **");
        $finish;
    end

    // One tag byte across the handshake. Called at a falling edge, returns at a
    // falling edge. valid stays high between back-to-back bytes; it is only
    // lowered inside the idle loop, so each step sees at most one assignment.
    task automatic send_byte(logic [7:0] b, bit f, bit l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tag_if.valid <= 1'b0;
            @(negedge clk);
        end
        tag_if.valid <= 1'b1;
        tag_if.data  <= '{tag_byte: b, first: f, last: l};
        @(posedge clk);
        while (!tag_if.ready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    // append one byte to the tag being composed
    function automatic void add_byte(logic [7:0] b);
        tag_text = {tag_text, b};
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    // Send the composed tag: first on its opening byte, last (if asked) on its final byte.
    task automatic send_tag(bit with_last);
        foreach (tag_text[i])
            send_byte(tag_text[i], i == 0, with_last && i == tag_text.size() - 1);
        tag_text.delete();
        tags_sent++;
    endtask

    task automatic directed_tag(string s, bit with_last = 1'b1);
        put_text(s);
        send_tag(with_last);
    endtask

    // any of the five HTML whitespace bytes, space most often
    function automatic void put_space();
        case ($urandom_range(7))
            0:       add_byte(ltsc_pkg::CH_TAB);
            1:       add_byte(ltsc_pkg::CH_LF);
            2:       add_byte(ltsc_pkg::CH_CR);
            3:       add_byte(ltsc_pkg::CH_FF);
            default: add_byte(ltsc_pkg::CH_SP);
        endcase
    endfunction

    function automatic void put_junk(int n);
        repeat (n)
            add_byte(8'($urandom_range(255)));
    endfunction

    // one value token: nearly half stylesheet in various cases, plus near misses and junk
    function automatic void put_token();
        case ($urandom_range(10))
            0, 1, 2: put_text("stylesheet");
            3:       put_text("StyleSheet");
            4:       put_text("STYLESHEET");
            5:       put_text("stylesheets");
            6:       put_text("style");
            7:       put_text("icon");
            8:       put_text("alternate");
            default: put_junk($urandom_range(1, 3));
        endcase
    endfunction

    function automatic void put_attr();
        logic [7:0] q;
        int         n_tok;
        // attribute name; an empty name can leave a bare equals sign
        case ($urandom_range(10))
            0, 1, 2, 3: put_text("rel");
            4:          put_text("REL");
            5:          put_text("rEl");
            6:          put_text("href");
            7:          put_text("re");
            8:          put_text("rell");
            9:          ;
            default:
            begin
                repeat ($urandom_range(1, 5))
                    add_byte(8'($urandom_range(97, 122)));
            end
        endcase
        case ($urandom_range(6))
            0: ;                                   // bare attribute
            1, 2:                                  // unquoted, single token
            begin
                add_byte(ltsc_pkg::CH_EQ);
                put_token();
            end
            default:                               // quoted, maybe spaced around '='
            begin
                if ($urandom_range(3) == 0)
                    put_space();
                add_byte(ltsc_pkg::CH_EQ);
                if ($urandom_range(3) == 0)
                    put_space();
                q = $urandom_range(2) == 0 ? ltsc_pkg::CH_SQ : ltsc_pkg::CH_DQ;
                add_byte(q);
                n_tok = $urandom_range(0, 3);
                for (int t = 0; t < n_tok; t++)
                begin
                    if (t != 0)
                        repeat ($urandom_range(1, 2)) put_space();
                    put_token();
                end
                add_byte(q);
            end
        endcase
    endfunction

    // Compose a tag with random content, sometimes without a closing byte or cut short.
    // Returns whether its final byte carries last.
    function automatic bit compose_tag();
        int keep;
        add_byte("<");
        case ($urandom_range(4))
            0:       put_text("link");
            1:       put_text("LINK");
            2:       put_text("a");
            3:       put_text("style");
            default: ;
        endcase
        repeat ($urandom_range(0, 3))
        begin
            repeat ($urandom_range(1, 2))
            begin
                if ($urandom_range(4) == 0)
                    add_byte(ltsc_pkg::CH_SLASH);
                else
                    put_space();
            end
            put_attr();
        end
        case ($urandom_range(7))
            0, 1, 2, 3: add_byte(ltsc_pkg::CH_GT);
            4:          put_text("/>");
            default:    ;
        endcase
        // truncation exercises the end-of-tag judgement mid-value
        if ($urandom_range(6) == 0)
        begin
            keep = $urandom_range(1, tag_text.size());
            while (tag_text.size() > keep)
                void'(tag_text.pop_back());
        end
        // a tag without last is abandoned by the next first byte
        return $urandom_range(11) != 0;
    endfunction

    initial
    begin
        rst_n            = 1'b0;
        tag_if.valid     = 1'b0;
        tag_if.data      = '0;
        verdict_if.ready = 1'b0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed tags, no idling ----
        directed_tag("<link rel=stylesheet>");
        // quoted value decides at the space after the matching token; rest ignored
        directed_tag("<LINK REL=\"alternate StyleSheet icon\">");
        // double quote is plain text inside a single-quoted value
        directed_tag("<link rel='x\"y stylesheet'>");
        directed_tag("<a href=x>");
        // bare '=' between attributes opens an attribute with an empty name
        directed_tag("<link =rel rel=STYLESHEET>");
        directed_tag("<link rel>");
        // tag cut off inside a value: judged on what was seen
        directed_tag("<link rel=styles");
        directed_tag("<link rel=\"stylesheet");
        directed_tag("<link rel=stylesheet");
        directed_tag("<link /rel/>");
        // opening byte that is also the final byte
        directed_tag("<");
        // bytes with no first while idle produce nothing
        send_byte("a", 1'b0, 1'b0);
        send_byte(ltsc_pkg::CH_GT, 1'b0, 1'b1);
        // byte zero and 0xFF as ordinary name/value characters
        put_text("<link r");
        add_byte(8'h00);
        put_text("l=");
        add_byte(8'hFF);
        put_text(" rel=stylesheet");
        add_byte(8'h00);
        put_text(">");
        send_tag(1'b1);
        // abandoned tag, then tab, line feed, carriage return and form feed around the attribute
        directed_tag("<link rel=\"sty", 1'b0);
        put_text("<link");
        add_byte(ltsc_pkg::CH_TAB);
        put_text("rel");
        add_byte(ltsc_pkg::CH_LF);
        add_byte(ltsc_pkg::CH_EQ);
        add_byte(ltsc_pkg::CH_CR);
        put_text("\"stylesheet\"");
        add_byte(ltsc_pkg::CH_FF);
        put_text(">");
        send_tag(1'b1);
        directed_tag("<link rel stylesheet>");
        directed_tag("<link rel=\"stylesheetx\">");
        directed_tag("<link rela=stylesheet re=stylesheet>");
        directed_tag("<link rel=a\tstylesheet>");
        directed_tag("<link rel=\"\"");
        directed_tag("<link>");
        // '>' inside a quoted value does not close the tag
        directed_tag("<link href=\"a>b\" rel=stylesheet>");

        // ---- random part: mostly composed tags, some raw noise, up to about 1200 bytes ----
        byte_goal = 1200;
        rand_tags = 0;
        while (bytes_sent < byte_goal)
        begin
            // rotate idling every few tags: none, sender, receiver, both
            idle_phase = (rand_tags / 6) % 4;
            send_idle_pct  = (idle_phase == 1) ? 53 : (idle_phase == 3) ? 27 : 0;
            recv_stall_pct = (idle_phase == 2) ? 53 : (idle_phase == 3) ? 27 : 0;
            if ($urandom_range(7) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(255)),
                              $urandom_range(3) == 0, $urandom_range(3) == 0);
            end
            else
            begin
                mark_last = compose_tag();
                send_tag(mark_last);
                // stray trailing bytes after the tag
                if ($urandom_range(9) == 0)
                    repeat ($urandom_range(1, 3))
                        send_byte(8'($urandom_range(255)), 1'b0, $urandom_range(1) == 0);
            end
            rand_tags++;
        end
        tag_if.valid <= 1'b0;

        // drain outstanding verdicts, then keep the clock running to catch any extra one
        while (verdicts_pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d tags in %0d bytes under four idling mixes;", tags_sent, bytes_sent);
        $display("checked %0d verdicts, %0d of them stylesheet.", verdicts_checked, stylesheet_count);
        if (mismatches == 0 && verdicts_pending == 0)
            $display("** link_tag_stylesheet_classifier_unit: PASSED **");
        else
            $display("** link_tag_stylesheet_classifier_unit: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
src/ltsc_pkg.sv
src/ltsc_stream_if.sv
src/ltsc_step.sv
src/link_tag_stylesheet_classifier_unit.sv
tb/ltsc_verdict_checker.sv
tb/tb_link_tag_stylesheet_classifier_unit.sv
